@@ hdl/legb_pkg.sv @@
// ----------------------------------------------------------------------------
// legb_pkg
// Shared types and constants of the gap buffer line editor: word layouts,
// key codes and the command that the control side hands to the cell row.
// ----------------------------------------------------------------------------
package legb_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int CAP_W         = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int COUNT_W       = $clog2(LINE_CAPACITY + 1);

  localparam logic [7:0] KEY_DELETE = 8'h2D;
  localparam logic [7:0] KEY_LEFT   = 8'h3C;
  localparam logic [7:0] KEY_RIGHT  = 8'h3E;

  typedef struct packed {
    logic       operation;
    logic [7:0] key_code;
  } in_word_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       char_valid;
    logic       line_last;
    logic       overflowed;
  } out_word_t;

  localparam logic OP_KEY   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [3:0] {
    CMD_HOLD   = 4'b0001,
    CMD_INSERT = 4'b0010,
    CMD_DELETE = 4'b0100,
    CMD_SHIFT  = 4'b1000
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic [COUNT_W-1:0] cursor;
    logic [7:0]         key;
  } cell_ctrl_t;

endpackage

@@ hdl/legb_cell.sv @@
// ----------------------------------------------------------------------------
// legb_cell
// One character position of the line. Holds its byte, takes the key, or
// takes the byte of the left or right neighbour as the command asks.
// ----------------------------------------------------------------------------
module legb_cell (
  input  logic                        clk,
  input  logic [legb_pkg::CAP_W-1:0]  idx,
  input  legb_pkg::cell_ctrl_t        ctrl,
  input  logic [7:0]                  left_char,
  input  logic [7:0]                  right_char,
  output logic [7:0]                  held
);

  logic [legb_pkg::COUNT_W-1:0] pos;
  logic [7:0]                   held_next;

  assign pos = legb_pkg::COUNT_W'(idx);

  always_comb begin
    held_next = held;
    case (ctrl.cmd)
      legb_pkg::CMD_INSERT: begin
        // cells at and past the cursor move one place right
        if (pos == ctrl.cursor) begin
          held_next = ctrl.key;
        end else if (pos > ctrl.cursor) begin
          held_next = left_char;
        end
      end
      legb_pkg::CMD_DELETE: begin
        if (pos >= ctrl.cursor) begin
          held_next = right_char;
        end
      end
      legb_pkg::CMD_SHIFT: begin
        held_next = right_char;
      end
      default: begin
        held_next = held;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    held <= held_next;
  end

endmodule

@@ hdl/line_edit_gap_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// line_edit_gap_buffer_unit
// Keystroke line editor built as a row of character cells with a cursor.
// ----------------------------------------------------------------------------
// Input channel in_valid / in_stall / in_word carries keystrokes and
// end-of-line words. A keystroke is applied when taken: insert and delete
// move the cells past the cursor one place in the row, cursor moves only
// change the counts. Keystrokes give no output.
// An end-of-line word starts a flush: the row shifts one cell a cycle
// towards cell 0 while out_stall is low, and cell 0 goes to the output
// register, so a line of N characters gives N words (one word for an
// empty line), loaded once the unit is in the flush state. in_stall is
// high for the whole flush and drops once the last word is registered,
// so the next keystroke can be taken while that word still waits.
// When the receiver raises out_stall the output register holds its word
// and the row stops shifting. Reset clears the counts, the overflow flag,
// the flush state and out_valid; cell contents are left as they are.
// ----------------------------------------------------------------------------
module line_edit_gap_buffer_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  legb_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output legb_pkg::out_word_t out_word
);

  localparam int CAP = legb_pkg::LINE_CAPACITY;
  localparam int CW  = legb_pkg::COUNT_W;

  typedef enum logic [1:0] {
    ST_EDIT  = 2'b01,
    ST_FLUSH = 2'b10
  } state_t;

  state_t               state;
  logic [CW-1:0]        left_count;
  logic [CW-1:0]        right_count;
  logic [CW-1:0]        remaining;
  logic                 overflow_flag;
  logic [CW-1:0]        total;
  logic                 take;
  logic                 load;
  legb_pkg::cell_ctrl_t ctrl;

  logic [7:0] cell_char [CAP];
  logic [7:0] left_in   [CAP];
  logic [7:0] right_in  [CAP];

  assign in_stall = (state != ST_EDIT);
  assign take     = in_valid && !in_stall;
  assign total    = left_count + right_count;
  assign load     = (state == ST_FLUSH) && (!out_valid || !out_stall);

  always_comb begin
    ctrl.cmd    = legb_pkg::CMD_HOLD;
    ctrl.cursor = left_count;
    ctrl.key    = in_word.key_code;
    if (take && in_word.operation == legb_pkg::OP_KEY) begin
      case (in_word.key_code)
        legb_pkg::KEY_DELETE: begin
          if (left_count != '0) begin
            ctrl.cmd    = legb_pkg::CMD_DELETE;
            ctrl.cursor = left_count - CW'(1);
          end
        end
        legb_pkg::KEY_LEFT, legb_pkg::KEY_RIGHT: begin
          ctrl.cmd = legb_pkg::CMD_HOLD;
        end
        default: begin
          if (total < CW'(CAP)) begin
            ctrl.cmd = legb_pkg::CMD_INSERT;
          end
        end
      endcase
    end else if (load && remaining != '0) begin
      ctrl.cmd = legb_pkg::CMD_SHIFT;
    end
  end

  // neighbour links, open at both ends of the row
  always_comb begin
    left_in[0]       = '0;
    right_in[CAP-1]  = '0;
    for (int i = 1; i < CAP; i++) begin
      left_in[i] = cell_char[i-1];
    end
    for (int i = 0; i < CAP - 1; i++) begin
      right_in[i] = cell_char[i+1];
    end
  end

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    legb_cell u_cell (
      .clk        (clk),
      .idx        (legb_pkg::CAP_W'(g)),
      .ctrl       (ctrl),
      .left_char  (left_in[g]),
      .right_char (right_in[g]),
      .held       (cell_char[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_EDIT;
      left_count    <= '0;
      right_count   <= '0;
      remaining     <= '0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_EDIT: begin
          if (take) begin
            if (in_word.operation == legb_pkg::OP_FLUSH) begin
              remaining   <= total;
              left_count  <= '0;
              right_count <= '0;
              state       <= ST_FLUSH;
            end else begin
              case (in_word.key_code)
                legb_pkg::KEY_DELETE: begin
                  if (left_count != '0) begin
                    left_count <= left_count - CW'(1);
                  end
                end
                legb_pkg::KEY_LEFT: begin
                  if (left_count != '0) begin
                    left_count  <= left_count - CW'(1);
                    right_count <= right_count + CW'(1);
                  end
                end
                legb_pkg::KEY_RIGHT: begin
                  if (right_count != '0) begin
                    left_count  <= left_count + CW'(1);
                    right_count <= right_count - CW'(1);
                  end
                end
                default: begin
                  if (total < CW'(CAP)) begin
                    left_count <= left_count + CW'(1);
                  end else begin
                    overflow_flag <= 1'b1;
                  end
                end
              endcase
            end
          end
        end
        ST_FLUSH: begin
          if (load) begin
            if (remaining <= CW'(1)) begin
              state         <= ST_EDIT;
              overflow_flag <= 1'b0;
            end
            if (remaining != '0) begin
              remaining <= remaining - CW'(1);
            end
          end
        end
        default: begin
          state <= ST_EDIT;
        end
      endcase
    end
  end

  // output word, loaded from the head of the row
  always_ff @(posedge clk) begin
    if (load) begin
      out_word.text_char  <= (remaining != '0) ? cell_char[0] : 8'h00;
      out_word.char_valid <= (remaining != '0);
      out_word.line_last  <= (remaining <= CW'(1));
      out_word.overflowed <= overflow_flag;
    end
  end

endmodule

@@ hdl/legb_checker.sv @@
// ----------------------------------------------------------------------------
// legb_checker
// Port-level checks of the line editor, bound to the top level.
// ----------------------------------------------------------------------------
module legb_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input legb_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input legb_pkg::out_word_t out_word
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // a word without a character only ever closes an empty line
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.char_valid |-> out_word.line_last)
    else $error("empty word not marked last");

  // no keystroke is taken in the middle of a line being sent
  a_busy_flush: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.line_last |-> in_stall)
    else $error("input open during flush");

  // end of line starts a flush at once
  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_word.operation |=> in_stall)
    else $error("no flush after end of line");

endmodule

bind line_edit_gap_buffer_unit legb_checker u_legb_checker (.*);
